FILE: rtl/core/aes_pkg.sv
// Package for the AES-128 core: S-box tables, GF(2^8) helpers, shared types.
// Used by every module in rtl/core; depends on nothing.
package aes_pkg;

  localparam int Rounds = 10;
  localparam int KeyW = 64;
  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow = 1'b1;

  typedef logic [127:0] blk_t;

  // Round tag carried along the row of cells.
  typedef struct packed {
    logic valid;
    logic func;
  } tag_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constants, first byte of each schedule word group.
  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 127-8i .. 120-8i.
  function automatic logic [7:0] byte_of(input blk_t b, input int i);
    byte_of = b[127 - 8*i -: 8];
  endfunction

  // Forward round: SubBytes, ShiftRows, optional MixColumns.
  function automatic blk_t enc_round(input blk_t s, input logic mixc);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127 - 8*(r + 4*c) -: 8] = SBOX[byte_of(s, r + 4*((c + r) % 4))];
    enc_round = t;
    if (mixc) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_of(t, 4*c); a1 = byte_of(t, 4*c+1);
        a2 = byte_of(t, 4*c+2); a3 = byte_of(t, 4*c+3);
        x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
        enc_round[127 - 32*c -: 32] = {x0 ^ x1 ^ a1 ^ a2 ^ a3, a0 ^ x1 ^ x2 ^ a2 ^ a3,
                                       a0 ^ a1 ^ x2 ^ x3 ^ a3, x0 ^ a0 ^ a1 ^ a2 ^ x3};
      end
    end
  endfunction

  // Inverse MixColumns.
  function automatic blk_t inv_mix(input blk_t s);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = byte_of(s, 4*c + k);
        m2[k] = xtime(a[k]); m4[k] = xtime(m2[k]); m8[k] = xtime(m4[k]);
        m9[k] = m8[k] ^ a[k]; mb[k] = m9[k] ^ m2[k];
        md[k] = m9[k] ^ m4[k]; me[k] = m8[k] ^ m4[k] ^ m2[k];
      end
      for (int r = 0; r < 4; r++)
        inv_mix[127 - 8*(4*c + r) -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
    end
  endfunction

  // Inverse ShiftRows and SubBytes.
  function automatic blk_t dec_sub(input blk_t s);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        dec_sub[127 - 8*(r + 4*((c + r) % 4)) -: 8] = ISBOX[byte_of(s, r + 4*c)];
  endfunction

  // Next round key from the previous one.
  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // Previous round key from the next one.
  function automatic blk_t prev_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    prev_key = {w0 ^ t, w1, w2, w3};
  endfunction

endpackage

FILE: rtl/core/aes_if.sv
// Valid/ready channel interfaces for the AES-128 core.
// Depends on aes_pkg for nothing but keeps the compile order.
interface aes_in_if (input logic clk);
  logic valid;
  logic ready;
  logic func;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, func, block_high, block_low, input ready);
  modport sink (input valid, func, block_high, block_low, output ready);
endinterface

interface aes_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

FILE: rtl/core/aes128_block_cipher_core.sv
// AES-128 encrypt/decrypt core: a key-add stage, ten round cells and an output skid.
// A result passes the key-add register and every round cell; one block per cycle while
// the input is not held off. The input is held off while the skid is full, and after
// reset or a key write while the decrypt start key is expanded one round per cycle.
// Synchronous active-high reset zeroes the key and clears all valid flags.
// Depends on aes_pkg, aes_if, aes_cell and aes_keyreg.
module aes128_block_cipher_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  aes_in_if.sink       in_ch,
  aes_out_if.source    out_ch
);

  aes_pkg::blk_t key, key_last;
  logic key_ready;
  aes_pkg::tag_t tg [aes_pkg::Rounds+1];
  aes_pkg::blk_t st [aes_pkg::Rounds+1];
  aes_pkg::blk_t kk [aes_pkg::Rounds+1];
  aes_pkg::blk_t in_blk;
  logic adv;
  logic skid_valid;
  aes_pkg::blk_t skid_data;

  aes_keyreg u_key (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index[0]),
    .cfg_data(cfg_data), .key(key), .key_last(key_last), .key_ready(key_ready)
  );

  // Pipe advances whenever the skid is empty; input also waits for the key walk.
  assign adv = !skid_valid;
  assign in_ch.ready = adv && key_ready;
  assign in_blk = {in_ch.block_high, in_ch.block_low};

  // Initial AddRoundKey stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tg[0].valid <= 1'b0;
    end else if (adv) begin
      tg[0].valid <= in_ch.valid && key_ready;
    end
    if (adv) begin
      tg[0].func <= in_ch.func;
      kk[0] <= in_ch.func ? key_last : key;
      st[0] <= in_blk ^ (in_ch.func ? key_last : key);
    end
  end

  for (genvar g = 0; g < aes_pkg::Rounds; g++) begin : g_cell
    aes_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .rc_enc(aes_pkg::RCON[g]), .rc_dec(aes_pkg::RCON[aes_pkg::Rounds-1-g]),
      .last(g == aes_pkg::Rounds - 1),
      .tag_in(tg[g]), .state_in(st[g]), .key_in(kk[g]),
      .tag(tg[g+1]), .state(st[g+1]), .key(kk[g+1])
    );
  end

  // Output stage: the last cell is the output register, skid catches a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ch.ready) skid_valid <= 1'b0;
    end else if (tg[aes_pkg::Rounds].valid && !out_ch.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) skid_data <= st[aes_pkg::Rounds];
  end

  assign out_ch.valid = skid_valid || tg[aes_pkg::Rounds].valid;
  assign out_ch.result_high = skid_valid ? skid_data[127:64] : st[aes_pkg::Rounds][127:64];
  assign out_ch.result_low = skid_valid ? skid_data[63:0] : st[aes_pkg::Rounds][63:0];

  // Skid and the last cell: when skid is full the pipe must be frozen.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !in_ch.ready) else $error("pipe runs with skid full");
  a_skid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(tg[aes_pkg::Rounds].valid))
    else $error("skid filled without result");
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> tg[0].valid) else $error("accepted block lost");
  a_key_gate: assert property (@(posedge clk) disable iff (rst)
    !key_ready |-> !in_ch.ready) else $error("input taken during key expansion");

endmodule

FILE: rtl/core/aes_cell.sv
// One round cell of the AES-128 pipeline: round transform and key step.
// Depends on aes_pkg.
module aes_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [7:0]        rc_enc,
  input  logic [7:0]        rc_dec,
  input  logic              last,
  input  aes_pkg::tag_t     tag_in,
  input  aes_pkg::blk_t     state_in,
  input  aes_pkg::blk_t     key_in,
  output aes_pkg::tag_t     tag,
  output aes_pkg::blk_t     state,
  output aes_pkg::blk_t     key
);

  aes_pkg::blk_t key_next;
  aes_pkg::blk_t state_next;
  aes_pkg::blk_t dsub;

  // Encrypt walks the schedule forward, decrypt walks it backward.
  always_comb begin
    if (tag_in.func) begin
      key_next = aes_pkg::prev_key(key_in, rc_dec);
      dsub = aes_pkg::dec_sub(state_in) ^ key_next;
      state_next = last ? dsub : aes_pkg::inv_mix(dsub);
    end else begin
      key_next = aes_pkg::next_key(key_in, rc_enc);
      dsub = '0;
      state_next = aes_pkg::enc_round(state_in, !last) ^ key_next;
    end
  end

  // Control bit clears on reset; payload just loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (adv) begin
      tag.valid <= tag_in.valid;
    end
    if (adv) begin
      tag.func <= tag_in.func;
      state <= state_next;
      key <= key_next;
    end
  end

endmodule

FILE: rtl/core/aes_keyreg.sv
// Key configuration registers and the decrypt start key (last round key).
// Depends on aes_pkg.
module aes_keyreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  output aes_pkg::blk_t     key,
  output aes_pkg::blk_t     key_last,
  output logic              key_ready
);

  aes_pkg::blk_t key_wr;
  aes_pkg::blk_t walk;
  logic [3:0] step;
  logic busy;

  // Key value after a write to the selected half.
  always_comb begin
    key_wr = key;
    case (cfg_index)
      aes_pkg::CfgKeyHigh: key_wr[127:64] = cfg_data;
      aes_pkg::CfgKeyLow: key_wr[63:0] = cfg_data;
      default: key_wr = key;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      key <= key_wr;
    end
  end

  // Walk the schedule one round per cycle up to the last round key.
  // A write restarts the walk from the new key.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
      step <= '0;
      busy <= 1'b1;
    end else if (cfg_we) begin
      walk <= key_wr;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      walk <= aes_pkg::next_key(walk, aes_pkg::RCON[step]);
      step <= step + 4'd1;
      if (step == 4'(aes_pkg::Rounds - 1)) busy <= 1'b0;
    end
  end

  assign key_last = walk;
  assign key_ready = !busy;

endmodule

FILE: sim/aes128_block_cipher_core_test.sv
// Self-checking testbench for the AES-128 encrypt/decrypt core.
// Depends on aes_pkg, aes_if and the aes128_block_cipher_core RTL.
`timescale 1ns / 100ps

module aes128_block_cipher_core_test;

  typedef enum logic { OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1 } op_t;

  typedef struct {
    op_t         op;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic        known;
    logic [127:0] res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = aes_pkg::CfgKeyHigh;
  logic [63:0] cfg_data = '0;

  aes_in_if in_ch (.clk(clk));
  aes_out_if out_ch (.clk(clk));

  aes128_block_cipher_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Cipher key as the core should hold it.
  logic [127:0] cipher_key = '0;
  logic [127:0] expected_blocks[$];
  logic [7:0] inv_sbox[256];
  int error_count = 0;
  int idle_cycles = 0;
  bit sink_no_idle = 0;
  bit sink_hold = 0;
  bit stim_done = 0;
  stim_row_t directed[$];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 256; i++) inv_sbox[aes_pkg::SBOX[i]] = i[7:0];
  end

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  // Straight FIPS-197 computation on a 16-byte state, byte 0 at the top.
  function automatic logic [127:0] aes_transform(input op_t op, input logic [127:0] blk,
                                                 input logic [127:0] key);
    logic [7:0] rk[11][16];
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] w[4];
    logic [7:0] col[4];
    logic [7:0] rc;
    logic [7:0] mf[4];
    logic [127:0] res;
    int rnd;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[0][i] = key[127 - 8*i -: 8];
    for (int k = 1; k < 11; k++) begin
      w[0] = aes_pkg::SBOX[rk[k-1][13]] ^ rc; w[1] = aes_pkg::SBOX[rk[k-1][14]];
      w[2] = aes_pkg::SBOX[rk[k-1][15]]; w[3] = aes_pkg::SBOX[rk[k-1][12]];
      rc = gf_double(rc);
      for (int i = 0; i < 16; i++) begin
        if (i < 4) rk[k][i] = rk[k-1][i] ^ w[i];
        else rk[k][i] = rk[k-1][i] ^ rk[k][i-4];
      end
    end
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8];
    if (op == OP_ENCRYPT) begin
      mf = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int i = 0; i < 16; i++) st[i] ^= rk[0][i];
      for (rnd = 1; rnd <= 10; rnd++) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) tmp[r + 4*c] = aes_pkg::SBOX[st[r + 4*((c + r) % 4)]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              col[r] = 0;
              for (int k = 0; k < 4; k++) col[r] ^= gf_mul(st[4*c + k], mf[(k - r + 4) % 4]);
            end
            for (int r = 0; r < 4; r++) st[4*c + r] = col[r];
          end
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[rnd][i];
      end
    end else begin
      mf = '{8'd14, 8'd11, 8'd13, 8'd9};
      for (int i = 0; i < 16; i++) st[i] ^= rk[10][i];
      for (rnd = 9; rnd >= 0; rnd--) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) tmp[r + 4*((c + r) % 4)] = inv_sbox[st[r + 4*c]];
        st = tmp;
        for (int i = 0; i < 16; i++) st[i] ^= rk[rnd][i];
        if (rnd > 0) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              col[r] = 0;
              for (int k = 0; k < 4; k++) col[r] ^= gf_mul(st[4*c + k], mf[(k - r + 4) % 4]);
            end
            for (int r = 0; r < 4; r++) st[4*c + r] = col[r];
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  // Write both key halves on consecutive edges.
  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    cfg_we <= 1'b1;
    cfg_index <= aes_pkg::CfgKeyHigh;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= aes_pkg::CfgKeyLow;
    cfg_data <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    cipher_key = {hi, lo};
  endtask

  // Offer one block and wait for the transaction; the expected result is queued then.
  task automatic send_block(input op_t op, input logic [63:0] hi, input logic [63:0] lo,
                            input logic known, input logic [127:0] res, input bit no_gap);
    while (!no_gap && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op;
    in_ch.block_high <= hi;
    in_ch.block_low <= lo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_blocks.insert(expected_blocks.size(),
                           known ? res : aes_transform(op, {hi, lo}, cipher_key));
  endtask

  // Wait for the pipeline to drain before a key change; cycles after for late outputs.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic random_blocks(input int count, input bit no_gap);
    for (int i = 0; i < count; i++)
      send_block(op_t'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
                 1'b0, '0, no_gap);
  endtask

  // Result side: random back-pressure, plus a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        sink_hold = 0;
      end
      out_ch.ready <= sink_no_idle || ($urandom_range(99) >= 32);
      @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h_%h", $time, out_ch.result_high, out_ch.result_low);
        error_count++;
      end else begin
        if (out_ch.result_high !== expected_blocks[0][127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   expected_blocks[0][127:64], out_ch.result_high);
          error_count++;
        end
        if (out_ch.result_low !== expected_blocks[0][63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   expected_blocks[0][63:0], out_ch.result_low);
          error_count++;
        end
        void'(expected_blocks.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst || stim_done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("** aes128_block_cipher_core: FAILED **");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = OP_ENCRYPT;
    in_ch.block_high = '0;
    in_ch.block_low = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero key after reset: the known all-zero vector, its inverse, and all-ones blocks both ways.
    add_row('{OP_ENCRYPT, 64'h0, 64'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
    add_row('{OP_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 128'h0});
    add_row('{OP_ENCRYPT, '1, '1, 1'b0, '0});
    add_row('{OP_DECRYPT, '1, '1, 1'b0, '0});
    foreach (directed[i])
      send_block(directed[i].op, directed[i].blk_hi, directed[i].blk_lo,
                 directed[i].known, directed[i].res, 1'b0);
    drain();

    // Standard FIPS-197 appendix vector both ways, plus further blocks checked against aes_transform.
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    directed.delete();
    add_row('{OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
              128'h69c4e0d86a7b0430d8cdb78070b4c55a});
    add_row('{OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
              128'h00112233445566778899aabbccddeeff});
    add_row('{OP_ENCRYPT, 64'h0, 64'h0, 1'b0, '0});
    add_row('{OP_DECRYPT, '1, '1, 1'b0, '0});
    add_row('{OP_ENCRYPT, 64'h8000000000000000, 64'h1, 1'b0, '0});
    add_row('{OP_DECRYPT, 64'h1, 64'h8000000000000000, 1'b0, '0});
    foreach (directed[i])
      send_block(directed[i].op, directed[i].blk_hi, directed[i].blk_lo,
                 directed[i].known, directed[i].res, 1'b0);
    drain();

    // All-ones key.
    write_key('1, '1);
    random_blocks(6, 1'b0);
    drain();

    // Random keys; one phase without gaps and one with a long result stall.
    for (int phase = 0; phase < 6; phase++) begin
      write_key({$urandom, $urandom}, {$urandom, $urandom});
      if (phase == 2) sink_no_idle = 1;
      if (phase == 4) sink_hold = 1;
      random_blocks(100, phase == 2);
      sink_no_idle = 0;
      drain();
    end

    stim_done = 1;
    if (error_count == 0 && expected_blocks.size() == 0)
      $display("** aes128_block_cipher_core: PASSED **");
    else
      $display("** aes128_block_cipher_core: FAILED **");
    $finish;
  end

endmodule
